@@ design/aar_pkg.sv @@
// ----------------------------------------------------------------------------
// aar_pkg
// shared types and constants of the area averaging resampler
// ----------------------------------------------------------------------------
`default_nettype none

package aar_pkg;

    localparam int unsigned SAMPLE_W      = 16;
    localparam int unsigned LOGIC_N       = 8;
    localparam int unsigned ANA_N         = 2;
    localparam int unsigned TIME_W        = 18;
    localparam int unsigned ANALOG_W      = 34;
    localparam int unsigned CNT_W         = 16;
    localparam int unsigned CFG_W         = 16;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned PROD_W        = ANALOG_W + TIME_W;
    localparam int unsigned DIV_STEPS     = PROD_W;
    localparam int unsigned STEP_W        = $clog2(DIV_STEPS);
    localparam int unsigned LANE_N        = 2 * ANA_N + LOGIC_N;
    localparam int unsigned MAX_BURST_DEF = 64;

    localparam logic [TIME_W:0] TIME_MAX = {1'b0, {TIME_W{1'b1}}};

    localparam logic [CFG_IDX_W-1:0] CFG_RAW_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 2'd2;

    typedef struct packed {
        logic                sweep_start;
        logic [SAMPLE_W-1:0] in_analog_a;
        logic [SAMPLE_W-1:0] in_analog_b;
        logic [LOGIC_N-1:0]  in_logic;
    } t_in_word;

    typedef struct packed {
        logic [SAMPLE_W-1:0] out_analog_a;
        logic [SAMPLE_W-1:0] out_analog_b;
        logic [LOGIC_N-1:0]  out_logic;
        logic                last_of_run;
    } t_out_word;

    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        logic commit;
        logic last;
        logic integ;
    } t_cmd;

    typedef struct packed {
        logic emit_ok;
        logic next_ok;
    } t_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_EMIT,
        ST_INTEG
    } t_state;

endpackage

`default_nettype wire

@@ design/aar_if.sv @@
// ----------------------------------------------------------------------------
// aar_if
// valid/ready word channels of the area averaging resampler
// ----------------------------------------------------------------------------
`default_nettype none

interface aar_in_if;
    logic             valid;
    logic             ready;
    aar_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface aar_out_if;
    logic              valid;
    logic              ready;
    aar_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/aar_div_lane.sv @@
// ----------------------------------------------------------------------------
// aar_div_lane
// restoring divider lane, one quotient bit per cycle while i_step is high
// ----------------------------------------------------------------------------
`default_nettype none

module aar_div_lane (
    input  wire logic                         i_clk,
    input  wire logic                         i_load,
    input  wire logic                         i_step,
    input  wire logic [aar_pkg::PROD_W-1:0]   i_dividend,
    input  wire logic [aar_pkg::TIME_W-1:0]   i_divisor,
    output logic      [aar_pkg::PROD_W-1:0]   o_quot
);

    logic [aar_pkg::PROD_W-1:0] r_num;
    logic [aar_pkg::TIME_W-1:0] r_rem;
    logic [aar_pkg::TIME_W:0]   w_sh;
    logic [aar_pkg::TIME_W:0]   w_diff;
    logic                       w_ge;

    assign w_sh   = {r_rem, r_num[aar_pkg::PROD_W-1]};
    assign w_ge   = w_sh >= {1'b0, i_divisor};
    assign w_diff = w_sh - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= i_dividend;
            r_rem <= '0;
        end else if (i_step) begin
            r_num <= {r_num[aar_pkg::PROD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[aar_pkg::TIME_W-1:0] : w_sh[aar_pkg::TIME_W-1:0];
        end
    end

    assign o_quot = r_num;

endmodule

`default_nettype wire

@@ design/aar_datapath.sv @@
// ----------------------------------------------------------------------------
// aar_datapath
// integrals, time, config registers, divider lanes and output word
// ----------------------------------------------------------------------------
`default_nettype none

module aar_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [aar_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [aar_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire aar_pkg::t_in_word               i_word,
    input  wire aar_pkg::t_cmd                   i_cmd,
    output aar_pkg::t_stat                       o_stat,
    output aar_pkg::t_out_word                   o_word
);

    localparam int unsigned AW = aar_pkg::ANALOG_W;
    localparam int unsigned TW = aar_pkg::TIME_W;
    localparam int unsigned SW = aar_pkg::SAMPLE_W;
    localparam int unsigned PW = aar_pkg::PROD_W;
    localparam int unsigned LN = aar_pkg::LOGIC_N;
    localparam int unsigned AN = aar_pkg::ANA_N;

    logic [aar_pkg::CFG_W-1:0] r_raw;
    logic [aar_pkg::CFG_W-1:0] r_oi;
    logic [aar_pkg::CFG_W-1:0] r_limit;

    logic [AW-1:0]             r_ai [AN];
    logic [TW-1:0]             r_li [LN];
    logic [TW-1:0]             r_t;
    logic [aar_pkg::CNT_W-1:0] r_cnt;
    logic [TW-1:0]             r_rest;
    logic [SW-1:0]             r_smp [AN];
    logic [LN-1:0]             r_bits;
    aar_pkg::t_out_word        r_out;

    logic [aar_pkg::CFG_W-1:0] w_oi;
    logic [TW-1:0]             w_rest;
    logic [PW-1:0]             w_div [aar_pkg::LANE_N];
    logic [PW-1:0]             w_quot [aar_pkg::LANE_N];
    logic [TW:0]               w_tsum;
    logic                      w_fits;
    logic [aar_pkg::CNT_W:0]   w_cnt1;
    logic [LN-1:0]             w_maj;
    logic [SW-1:0]             w_avg [AN];

    assign w_oi   = (r_oi == '0) ? aar_pkg::CFG_W'(1) : r_oi;
    assign w_rest = r_t - TW'(w_oi);
    assign w_tsum = {1'b0, r_t} + (TW + 1)'(r_raw);
    assign w_fits = w_tsum <= aar_pkg::TIME_MAX;
    assign w_cnt1 = {1'b0, r_cnt} + (aar_pkg::CNT_W + 1)'(1);

    assign o_stat.emit_ok = (r_t >= TW'(w_oi)) && (r_cnt < r_limit);
    assign o_stat.next_ok = (r_rest >= TW'(w_oi)) && (w_cnt1 < {1'b0, r_limit});

    genvar g;
    generate
        for (g = 0; g < AN; g++) begin : g_ana
            assign w_div[g]      = PW'(r_ai[g]);
            assign w_div[AN + g] = PW'(r_ai[g]) * PW'(w_rest);
            assign w_avg[g] = (w_quot[g][PW-1:SW] != '0) ? {SW{1'b1}} : w_quot[g][SW-1:0];
        end
        for (g = 0; g < LN; g++) begin : g_lgc
            assign w_div[2 * AN + g] = PW'(r_li[g]) * PW'(w_rest);
            assign w_maj[g] = {r_li[g], 1'b0} >= {1'b0, r_t};
        end
        for (g = 0; g < aar_pkg::LANE_N; g++) begin : g_lane
            aar_div_lane u_lane (
                .i_clk      (i_clk),
                .i_load     (i_cmd.load),
                .i_step     (i_cmd.step),
                .i_dividend (w_div[g]),
                .i_divisor  (r_t),
                .o_quot     (w_quot[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw   <= aar_pkg::CFG_W'(1);
            r_oi    <= aar_pkg::CFG_W'(1);
            r_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aar_pkg::CFG_RAW_INTERVAL: r_raw   <= i_cfg_data;
                aar_pkg::CFG_OUT_INTERVAL: r_oi    <= i_cfg_data;
                aar_pkg::CFG_OUTPUT_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AN; i++) r_ai[i] <= '0;
            for (int i = 0; i < LN; i++) r_li[i] <= '0;
            r_t   <= '0;
            r_cnt <= '0;
        end else if (i_cmd.accept && i_word.sweep_start) begin
            for (int i = 0; i < AN; i++) r_ai[i] <= '0;
            for (int i = 0; i < LN; i++) r_li[i] <= '0;
            r_t   <= '0;
            r_cnt <= '0;
        end else if (i_cmd.commit) begin
            for (int i = 0; i < AN; i++) r_ai[i] <= w_quot[AN + i][AW-1:0];
            for (int i = 0; i < LN; i++) r_li[i] <= w_quot[2 * AN + i][TW-1:0];
            r_t   <= r_rest;
            r_cnt <= w_cnt1[aar_pkg::CNT_W-1:0];
        end else if (i_cmd.integ && w_fits) begin
            for (int i = 0; i < AN; i++) r_ai[i] <= r_ai[i] + AW'(r_raw) * AW'(r_smp[i]);
            for (int i = 0; i < LN; i++) r_li[i] <= r_bits[i] ? r_li[i] + TW'(r_raw) : r_li[i];
            r_t <= w_tsum[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_smp[0] <= i_word.in_analog_a;
            r_smp[1] <= i_word.in_analog_b;
            r_bits   <= i_word.in_logic;
        end
        if (i_cmd.load) begin
            r_rest <= w_rest;
        end
        if (i_cmd.commit) begin
            r_out.out_analog_a <= w_avg[0];
            r_out.out_analog_b <= w_avg[1];
            r_out.out_logic    <= w_maj;
            r_out.last_of_run  <= i_cmd.last;
        end
    end

    assign o_word = r_out;

endmodule

`default_nettype wire

@@ design/aar_ctrl.sv @@
// ----------------------------------------------------------------------------
// aar_ctrl
// sequencer: emission check, divide run, output handoff, integration
// ----------------------------------------------------------------------------
`default_nettype none

module aar_ctrl #(
    parameter int unsigned MAX_BURST = aar_pkg::MAX_BURST_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire aar_pkg::t_stat i_stat,
    output aar_pkg::t_cmd       o_cmd
);

    localparam int unsigned BW = $clog2(MAX_BURST + 1);

    aar_pkg::t_state               r_state, n_state;
    logic [BW-1:0]                 r_burst, n_burst;
    logic [aar_pkg::STEP_W-1:0]    r_step, n_step;
    logic                          r_ov, n_ov;
    logic [BW-1:0]                 w_burst1;
    logic                          w_free;

    assign w_burst1 = r_burst + BW'(1);
    assign w_free   = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aar_pkg::ST_IDLE;
            r_burst <= '0;
            r_step  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_burst <= n_burst;
            r_step  <= n_step;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state = r_state;
        n_burst = r_burst;
        n_step  = r_step;
        n_ov    = r_ov && !i_out_ready;
        o_cmd   = '0;
        unique case (r_state)
            aar_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_burst      = '0;
                    n_state      = aar_pkg::ST_CHECK;
                end
            end
            aar_pkg::ST_CHECK: begin
                if (i_stat.emit_ok && (r_burst < BW'(MAX_BURST))) begin
                    n_state = aar_pkg::ST_MUL;
                end else begin
                    n_state = aar_pkg::ST_INTEG;
                end
            end
            aar_pkg::ST_MUL: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = aar_pkg::ST_DIV;
            end
            aar_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + aar_pkg::STEP_W'(1);
                if (r_step == aar_pkg::STEP_W'(aar_pkg::DIV_STEPS - 1)) begin
                    n_state = aar_pkg::ST_EMIT;
                end
            end
            aar_pkg::ST_EMIT: begin
                if (w_free) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.last   = !(i_stat.next_ok && (w_burst1 < BW'(MAX_BURST)));
                    n_ov         = 1'b1;
                    n_burst      = w_burst1;
                    n_state      = aar_pkg::ST_CHECK;
                end
            end
            aar_pkg::ST_INTEG: begin
                o_cmd.integ = 1'b1;
                n_state     = aar_pkg::ST_IDLE;
            end
            default: n_state = aar_pkg::ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == aar_pkg::ST_IDLE);
    assign o_out_valid = r_ov;

endmodule

`default_nettype wire

@@ design/area_average_resampler.sv @@
// ----------------------------------------------------------------------------
// area_average_resampler
// time-area averaging resampler for two analog channels and eight logic bits
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one raw sample word per handshake; o_out carries averaged
//   words, last_of_run marking the final word caused by one input word.
//   registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; write
//   them only while the block is idle, which the block does not enforce.
// sequence:
//   an input word causing no output passes accept, check and integrate.
//   each output word adds check, product load, the divide run of the twelve
//   shared-divisor restoring divider lanes, which produce one quotient bit per
//   cycle, then the handoff, which waits while the output register is held.
//   one input word is worked on at a time; i_in.ready is high only while
//   the sequencer is idle.
// reset:
//   synchronous, active low; integrals, time and count clear, raw and
//   output intervals go to 1 and the output limit to 0.
// stall:
//   the output register holds its word while o_out.ready is low; the next
//   word waits in the divider until the register frees, and a new input
//   word is taken even while the last output word waits.
// ----------------------------------------------------------------------------
`default_nettype none

module area_average_resampler #(
    parameter int unsigned MAX_BURST = aar_pkg::MAX_BURST_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    aar_in_if.sink                             i_in,
    aar_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [aar_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [aar_pkg::CFG_W-1:0]     i_cfg_data
);

    aar_pkg::t_cmd      w_cmd;
    aar_pkg::t_stat     w_stat;
    aar_pkg::t_out_word w_word;
    logic               w_in_ready;
    logic               w_out_valid;

    aar_ctrl #(
        .MAX_BURST (MAX_BURST)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    aar_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_word     (i_in.data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_word     (w_word)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.data  = w_word;

endmodule

`default_nettype wire

@@ design/aar_checker.sv @@
// ----------------------------------------------------------------------------
// aar_checker
// port-level checks of the area averaging resampler
// ----------------------------------------------------------------------------
`default_nettype none

module aar_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire aar_pkg::t_out_word i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output word dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while previous word in work");

    a_no_out_at_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("output word appeared right after accept");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

endmodule

bind area_average_resampler aar_checker u_aar_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
